// ===== src/alsp_pkg.sv =====
// ----------------------------------------------------------------------------
// alsp_pkg: shared types and constants for the antialiased line stepper
// Holds default widths, register indexes, reset values and the state types.
// ----------------------------------------------------------------------------
package alsp_pkg;

    // default geometry
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int COLOR_BITS     = 24;

    // configuration port
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_BITS-1:0]     WIDTH_RESET      = 13'd640;
    localparam logic [CFG_BITS-1:0]     HEIGHT_RESET     = 13'd480;

    // item kinds on the input tuser
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    // front sequencer
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_PREP,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    // line progress in the back part
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SECOND,
        PH_INTERIOR
    } t_phase;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/als_queue.sv =====
// ----------------------------------------------------------------------------
// als_queue: short command queue between front and back
// Two-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module als_queue #(
    parameter int WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_rdata,
    output alsp_pkg::t_q_status  o_status
);
    import alsp_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_count, n_count;

    // pointer and fill count
    always_comb begin
        n_wptr  = r_wptr + i_push;
        n_rptr  = r_rptr + i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rptr];
    assign o_status.full  = r_count[1];
    assign o_status.empty = (r_count == 2'd0);

endmodule

// ===== src/als_front.sv =====
// ----------------------------------------------------------------------------
// als_front: item intake, line setup and slope division
// Steps pass straight to the queue; a start orders the endpoints and runs a
// restoring divider one quotient bit per cycle before pushing its command.
// ----------------------------------------------------------------------------
module als_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    localparam int CMD_W = 4 * COORD_BITS + FRAC_BITS + 4 + alsp_pkg::COLOR_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  logic                                         i_in_action,
    input  logic [4*COORD_BITS+alsp_pkg::COLOR_BITS-1:0] i_in_data,
    input  alsp_pkg::t_q_status                          i_q_status,
    output logic                                         o_push,
    output logic [CMD_W-1:0]                             o_cmd
);
    import alsp_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int QW    = COORD_BITS + 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int SW    = FRAC_BITS + 2;

    t_front_state r_state, n_state;

    logic signed [CB-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [CB:0]   r_dx0, r_dy0;
    logic [COLOR_BITS-1:0] r_color;
    logic                 r_steep, r_neg;
    logic [CB:0]          r_dvs;
    logic [CB+1:0]        r_rem;
    logic [QW-1:0]        r_quo;
    logic [CNT_W-1:0]     r_cnt;

    logic signed [CB-1:0] in_x1, in_y1, in_x2, in_y2;
    logic [CB:0]          adx, ady;
    logic                 steep, flip;
    logic signed [CB-1:0] maj1, min1, maj2, min2;
    logic signed [CB:0]   dmin;
    logic [CB+1:0]        trial;
    logic                 qbit;
    logic signed [SW-1:0] slope;
    logic [SW-1:0]        qmag;

    // input fields
    assign in_x1 = i_in_data[CB-1:0];
    assign in_y1 = i_in_data[2*CB-1:CB];
    assign in_x2 = i_in_data[3*CB-1:2*CB];
    assign in_y2 = i_in_data[4*CB-1:3*CB];

    // axis choice and endpoint order from the registered differences
    always_comb begin
        adx   = r_dx0[CB] ? (CB+1)'(-r_dx0) : r_dx0;
        ady   = r_dy0[CB] ? (CB+1)'(-r_dy0) : r_dy0;
        steep = ady > adx;
        maj1  = steep ? r_y1 : r_x1;
        min1  = steep ? r_x1 : r_y1;
        maj2  = steep ? r_y2 : r_x2;
        min2  = steep ? r_x2 : r_y2;
        flip  = steep ? r_dy0[CB] : r_dx0[CB];
        dmin  = steep ? r_dx0 : r_dy0;
    end

    // one restoring step
    always_comb begin
        trial = {r_rem[CB:0], r_quo[QW-1]};
        qbit  = trial >= {1'b0, r_dvs};
    end

    // slope from the quotient, one when the major span is zero
    always_comb begin
        qmag = SW'(r_quo[FRAC_BITS:0]);
        if (r_dvs == '0) begin
            slope = SW'(1) << FRAC_BITS;
        end else begin
            slope = r_neg ? SW'(-qmag) : qmag;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshakes
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd[CMD_W-1] = 1'b0;
        case (r_state)
            FS_IDLE: begin
                o_in_ready = !i_q_status.full;
                o_cmd      = {1'b0, {(CMD_W-1){1'b0}}};
                if (i_in_valid && !i_q_status.full) begin
                    if (i_in_action == ACT_STEP) begin
                        o_push = 1'b1;
                    end else begin
                        n_state = FS_PREP;
                    end
                end
            end
            FS_PREP: begin
                n_state = FS_DIV;
            end
            FS_DIV: begin
                if (r_cnt == '0) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                o_cmd = {1'b1, r_steep, r_x1, r_y1, r_x2, r_y2, slope, r_color};
                if (!i_q_status.full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    // setup and divider datapath
    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_in_valid && o_in_ready) begin
            r_x1    <= in_x1;
            r_y1    <= in_y1;
            r_x2    <= in_x2;
            r_y2    <= in_y2;
            r_color <= i_in_data[4*CB+COLOR_BITS-1:4*CB];
            r_dx0   <= (CB+1)'($signed(in_x2)) - (CB+1)'($signed(in_x1));
            r_dy0   <= (CB+1)'($signed(in_y2)) - (CB+1)'($signed(in_y1));
        end
        if (r_state == FS_PREP) begin
            r_steep <= steep;
            r_x1    <= flip ? maj2 : maj1;
            r_y1    <= flip ? min2 : min1;
            r_x2    <= flip ? maj1 : maj2;
            r_y2    <= flip ? min1 : min2;
            r_neg   <= dmin[CB] ^ flip;
            r_dvs   <= steep ? ady : adx;
            r_rem   <= '0;
            r_quo   <= {(steep ? adx : ady), {FRAC_BITS{1'b0}}};
            r_cnt   <= CNT_W'(QW);
        end
        if (r_state == FS_DIV && r_cnt != '0) begin
            r_rem <= qbit ? trial - {1'b0, r_dvs} : trial;
            r_quo <= {r_quo[QW-2:0], qbit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== src/als_back.sv =====
// ----------------------------------------------------------------------------
// als_back: line stepping, shading and result register
// Holds the line state and frame size, turns each queued command into one
// pixel pair or empty result, and keeps it in an output register until taken.
// ----------------------------------------------------------------------------
module als_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    localparam int CMD_W  = 4 * COORD_BITS + FRAC_BITS + 4 + alsp_pkg::COLOR_BITS,
    localparam int DATA_W = ((4 * COORD_BITS + 66 + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [alsp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [alsp_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    input  logic [CMD_W-1:0]                  i_cmd,
    input  alsp_pkg::t_q_status               i_q_status,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [DATA_W-1:0]                 o_data,
    output logic                              o_user,
    output logic                              o_last
);
    import alsp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SW  = F + 2;
    localparam int MW  = CB + 2;
    localparam int IW  = CB + F + 3;
    localparam int EW  = MW + CFG_BITS;
    localparam int RAW = 4 * CB + 66;

    // configuration registers
    logic [CFG_BITS-1:0] r_frame_width, r_frame_height;

    // line state
    t_phase               r_phase, n_phase;
    logic                 r_steep;
    logic [COLOR_BITS-1:0] r_color;
    logic signed [CB:0]   r_col_now;
    logic signed [CB-1:0] r_col_stop, r_far_row;
    logic signed [IW-1:0] r_icpt;
    logic signed [SW-1:0] r_slope;

    // output register
    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_user, r_last;

    // command fields
    logic                  c_start, c_steep;
    logic signed [CB-1:0]  c_x1, c_y1, c_x2, c_y2;
    logic signed [SW-1:0]  c_slope;
    logic [COLOR_BITS-1:0] c_color;

    logic                  e_valid, e_last, e_steep;
    logic [COLOR_BITS-1:0] e_color;
    logic signed [MW-1:0]  e_major, e_minor, nx, ny, fx, fy;
    logic [F:0]            e_bn, e_bf;
    logic [F-1:0]          frac;
    logic [7:0]            n_chan [3];
    logic [7:0]            f_chan [3];
    logic [F+9:0]          prod;
    logic                  near_in, far_in;
    logic [RAW-1:0]        e_raw;
    logic signed [CB+1:0]  col_next;

    assign {c_start, c_steep, c_x1, c_y1, c_x2, c_y2, c_slope, c_color} = i_cmd;

    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    // frame test against the unwrapped coordinate
    function automatic logic in_axis(logic signed [MW-1:0] v, logic [CFG_BITS-1:0] lim);
        logic [EW-1:0] ve, le;
        ve = EW'(unsigned'(v));
        le = EW'(lim);
        return !v[MW-1] && (ve < le);
    endfunction

    // select what this command emits
    always_comb begin
        frac     = r_icpt[F-1:0];
        col_next = (CB+2)'(r_col_now) + 1'b1;
        e_valid  = 1'b1;
        e_last   = 1'b0;
        e_steep  = r_steep;
        e_color  = r_color;
        e_major  = MW'(r_col_now);
        e_minor  = MW'(r_icpt >>> F);
        e_bn     = (F+1)'(1) << (F - 1);
        e_bf     = '0;
        n_phase  = r_phase;
        if (c_start) begin
            e_steep = c_steep;
            e_color = c_color;
            e_major = MW'(c_x1);
            e_minor = MW'(c_y1);
            n_phase = PH_SECOND;
        end else begin
            case (r_phase)
                PH_SECOND: begin
                    e_major = MW'(r_col_stop);
                    e_minor = MW'(r_far_row);
                    e_last  = r_col_now >= (CB+1)'(r_col_stop);
                    n_phase = e_last ? PH_IDLE : PH_INTERIOR;
                end
                PH_INTERIOR: begin
                    e_bn    = ((F+1)'(1) << F) - (F+1)'(frac);
                    e_bf    = (F+1)'(frac);
                    e_last  = col_next >= (CB+2)'(r_col_stop);
                    n_phase = e_last ? PH_IDLE : PH_INTERIOR;
                end
                default: begin
                    e_valid = 1'b0;
                end
            endcase
        end
    end

    // pixel pair and shading
    always_comb begin
        nx = e_steep ? e_minor : e_major;
        ny = e_steep ? e_major : e_minor;
        fx = e_steep ? e_minor + 1'b1 : e_major;
        fy = e_steep ? e_major : e_minor + 1'b1;
        prod = '0;
        for (int k = 0; k < 3; k++) begin
            prod = (F+10)'(e_color[8*k +: 8]) * (F+10)'(e_bn) + ((F+10)'(1) << (F - 1));
            n_chan[k] = prod[F+7:F];
            prod = (F+10)'(e_color[8*k +: 8]) * (F+10)'(e_bf) + ((F+10)'(1) << (F - 1));
            f_chan[k] = prod[F+7:F];
        end
        near_in = in_axis(nx, r_frame_width) && in_axis(ny, r_frame_height);
        far_in  = in_axis(fx, r_frame_width) && in_axis(fy, r_frame_height);
        e_raw = {far_in, 8'hff, f_chan[2], f_chan[1], f_chan[0],
                 fy[CB-1:0], fx[CB-1:0],
                 near_in, 8'hff, n_chan[2], n_chan[1], n_chan[0],
                 ny[CB-1:0], nx[CB-1:0]};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // line state and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= e_valid ? DATA_W'(e_raw) : '0;
            r_user <= e_valid;
            r_last <= e_valid && e_last;
            if (c_start) begin
                r_steep    <= c_steep;
                r_color    <= c_color;
                r_col_now  <= (CB+1)'(c_x1) + 1'b1;
                r_col_stop <= c_x2;
                r_far_row  <= c_y2;
                r_slope    <= c_slope;
                r_icpt     <= (IW'(c_y1) <<< F) + IW'(c_slope);
            end else if (r_phase == PH_INTERIOR) begin
                r_col_now <= r_col_now + 1'b1;
                r_icpt    <= r_icpt + IW'(r_slope);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

// ===== src/antialiased_line_stepper.sv =====
// ----------------------------------------------------------------------------
// antialiased_line_stepper: Wu antialiased line generator
// Channel      Dir  Payload
// s_axis       in   tuser action, tdata start_x start_y end_x end_y line_color
// m_axis       out  tuser pair_valid, tlast last_pair, tdata pixel pair
// cfg          in   write enable, index, 13-bit data
// A step item is pushed to the queue in the same cycle it is accepted; results
// leave one per cycle when m_axis is ready and commands are queued. A start item
// passes the front part through setup, bit-serial slope division and the push.
// Reset is synchronous, active low; frame size returns to 640 x 480.
// Front and back meet in a two-entry queue, so each side stalls on its own.
// ----------------------------------------------------------------------------
module antialiased_line_stepper #(
    parameter int COORD_BITS = alsp_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = alsp_pkg::DEF_FRAC_BITS,
    localparam int IN_W   = ((4 * COORD_BITS + alsp_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((4 * COORD_BITS + 66 + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color, zero fill
    input  logic [IN_W-1:0]                   s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // near_x, near_y, near_color, near_write, far_x, far_y, far_color,
    // far_write, zero fill
    output logic [OUT_W-1:0]                  m_axis_tdata,
    // pair_valid
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [alsp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [alsp_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    import alsp_pkg::*;

    localparam int CMD_W   = 4 * COORD_BITS + FRAC_BITS + 4 + COLOR_BITS;
    localparam int NEAR_WR = 2 * COORD_BITS + 32;

    logic             push, pop;
    logic [CMD_W-1:0] cmd_in, cmd_out;
    t_q_status        q_status;

    // intake and setup
    als_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_action(s_axis_tuser),
        .i_in_data  (s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:0]),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    // command queue
    als_queue #(
        .WIDTH(CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (cmd_in),
        .i_pop   (pop),
        .o_rdata (cmd_out),
        .o_status(q_status)
    );

    // stepping and output
    als_back #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd_out),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_user     (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // last marks only real pixel pairs
    a_last_is_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last pair without pixel pair");

    // a near pixel write needs a pixel pair
    a_write_is_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[NEAR_WR] |-> m_axis_tuser)
        else $error("near write without pixel pair");

    // a start transfer holds off intake while the slope is divided
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_START) |=> !s_axis_tready)
        else $error("intake open during line setup");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the antialiased line stepper
// Drives start and step items with random gaps on both streams and predicts
// every pixel pair. Each pair is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import alsp_pkg::*;

    localparam int  ONE        = 65536;
    localparam int  ITEMS      = 1850;
    localparam int  SETTLE     = 60;
    localparam longint LIMIT   = 1000000;

    typedef struct {
        logic [15:0] near_x;
        logic [15:0] near_y;
        logic [31:0] near_color;
        logic        near_write;
        logic [15:0] far_x;
        logic [15:0] far_y;
        logic [31:0] far_color;
        logic        far_write;
        logic        pair_valid;
        logic        last_pair;
    } t_pair;

    // one row of the directed table: an item or a frame size change
    typedef struct {
        bit          cfg;
        logic        act;
        logic [87:0] d;
        int          reps;
        bit          typed;
        t_pair       want;
        int          w;
        int          h;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // start_x, start_y, end_x, end_y, line_color, zero fill
    logic [87:0]  s_axis_tdata = '0;
    // action
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // near_x, near_y, near_color, near_write, far_x, far_y, far_color,
    // far_write, zero fill
    logic [135:0] m_axis_tdata;
    // pair_valid
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_BITS-1:0]     i_cfg_wdata = '0;

    antialiased_line_stepper dut (.*);

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    longint frame_w = 640, frame_h = 480;
    bit     is_steep;
    t_phase line_phase = PH_IDLE;
    longint col_now, col_stop, end_row, icept, slope;
    logic [23:0] colour;

    t_pair  pair_q[$];
    int     errors = 0;
    int     items_sent = 0;
    bit     hold_req = 1'b0;
    bit     burst = 1'b0;
    longint cycles = 0;

    function automatic logic [31:0] shade(logic [23:0] rgb, longint bright);
        logic [31:0] c;
        c[31:24] = 8'hff;
        for (int k = 0; k < 3; k++)
            c[k*8 +: 8] = 8'((longint'(rgb[k*8 +: 8]) * bright + 32768) >>> 16);
        return c;
    endfunction

    function automatic bit in_frame(longint x, longint y);
        return x >= 0 && y >= 0 && x < frame_w && y < frame_h;
    endfunction

    function automatic t_pair make_pair(longint major, longint minor, longint bn,
                                        longint bf, bit last);
        t_pair  p;
        longint nx, ny, fx, fy;
        nx = is_steep ? minor : major;
        ny = is_steep ? major : minor;
        fx = is_steep ? minor + 1 : major;
        fy = is_steep ? major : minor + 1;
        p.near_x = 16'(nx);
        p.near_y = 16'(ny);
        p.near_color = shade(colour, bn);
        p.near_write = in_frame(nx, ny);
        p.far_x = 16'(fx);
        p.far_y = 16'(fy);
        p.far_color = shade(colour, bf);
        p.far_write = in_frame(fx, fy);
        p.pair_valid = 1'b1;
        p.last_pair = last;
        return p;
    endfunction

    // next pixel pair of the line, updating the line state
    task automatic next_pixel_pair(input logic act, input logic [87:0] d, output t_pair p);
        longint x1, y1, x2, y2, t, dx, dy, frac, row;
        bit     last;
        p = '{default: '0};
        if (act == ACT_START) begin
            x1 = longint'($signed(d[15:0]));
            y1 = longint'($signed(d[31:16]));
            x2 = longint'($signed(d[47:32]));
            y2 = longint'($signed(d[63:48]));
            dx = (x2 > x1) ? x2 - x1 : x1 - x2;
            dy = (y2 > y1) ? y2 - y1 : y1 - y2;
            is_steep = dy > dx;
            if (is_steep) begin
                t = x1; x1 = y1; y1 = t;
                t = x2; x2 = y2; y2 = t;
            end
            if (x1 > x2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx = x2 - x1;
            dy = y2 - y1;
            slope = (dx != 0) ? (dy * ONE) / dx : ONE;
            colour = d[87:64];
            col_now = x1 + 1;
            col_stop = x2;
            end_row = y2;
            icept = y1 * ONE + slope;
            line_phase = PH_SECOND;
            p = make_pair(x1, y1, 32768, 0, 1'b0);
        end else if (line_phase == PH_SECOND) begin
            last = col_now >= col_stop;
            p = make_pair(col_stop, end_row, 32768, 0, last);
            line_phase = last ? PH_IDLE : PH_INTERIOR;
        end else if (line_phase == PH_INTERIOR) begin
            frac = icept & (ONE - 1);
            row = (icept - frac) / ONE;
            last = col_now + 1 >= col_stop;
            p = make_pair(col_now, row, ONE - frac, frac, last);
            col_now += 1;
            icept += slope;
            if (last) line_phase = PH_IDLE;
        end
    endtask

    // one input transfer; typed expectation used when given
    task automatic send_item(input logic act, input logic [87:0] d,
                             input bit typed = 0, input t_pair want = '{default: '0});
        t_pair p;
        int    gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = d;
        do @(posedge i_clk); while (!s_axis_tready);
        next_pixel_pair(act, d, p);
        pair_q.push_back(typed ? want : p);
        items_sent++;
        @(negedge i_clk);
    endtask

    // wait for all pairs to drain, let the front part settle, then reconfigure
    task automatic reconfigure(input int w, input int h);
        s_axis_tvalid = 1'b0;
        while (pair_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_wdata = CFG_BITS'(w);
        @(negedge i_clk);
        i_cfg_index = CFG_FRAME_HEIGHT;
        i_cfg_wdata = CFG_BITS'(h);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        frame_w = w;
        frame_h = h;
    endtask

    function automatic logic [87:0] pack_line(int x1, int y1, int x2, int y2,
                                              logic [23:0] c);
        return {c, 16'(y2), 16'(x2), 16'(y1), 16'(x1)};
    endfunction

    // table rows
    function automatic t_row item_row(logic act, logic [87:0] d, int reps = 1,
                                      bit typed = 0, t_pair want = '{default: '0});
        t_row r;
        r = '{default: '0};
        r.act   = act;
        r.d     = d;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row cfg_row(int w, int h);
        t_row r;
        r = '{default: '0};
        r.cfg = 1'b1;
        r.w   = w;
        r.h   = h;
        return r;
    endfunction

    // result receiver with random stalls and one long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            gap = burst ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_pair e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pair_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pair_q.pop_front();
                check_field("near_x", e.near_x, m_axis_tdata[15:0]);
                check_field("near_y", e.near_y, m_axis_tdata[31:16]);
                check_field("near_color", e.near_color, m_axis_tdata[63:32]);
                check_field("near_write", e.near_write, m_axis_tdata[64]);
                check_field("far_x", e.far_x, m_axis_tdata[80:65]);
                check_field("far_y", e.far_y, m_axis_tdata[96:81]);
                check_field("far_color", e.far_color, m_axis_tdata[128:97]);
                check_field("far_write", e.far_write, m_axis_tdata[129]);
                check_field("pair_valid", e.pair_valid, m_axis_tuser);
                check_field("last_pair", e.last_pair, m_axis_tlast);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_pair z, pt;
        t_row  rows[$];
        int    w, h, x1, y1, span, steps, dir, mx, my;
        bit    steep;
        z = '{default: '0};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: idle step after reset, single point line, extremes
        rows.push_back(item_row(ACT_STEP, '0, 1, 1, z));
        pt = '{16'd0, 16'd0, 32'hff808080, 1'b1, 16'd0, 16'd1, 32'hff000000, 1'b1,
               1'b1, 1'b0};
        rows.push_back(item_row(ACT_START, pack_line(0, 0, 0, 0, 24'hffffff), 1, 1, pt));
        pt.last_pair = 1'b1;
        rows.push_back(item_row(ACT_STEP, '0, 1, 1, pt));
        rows.push_back(item_row(ACT_STEP, '1, 1, 1, z));
        rows.push_back(item_row(ACT_START,
                                pack_line(-32768, -32768, 32767, 32767, 24'h000000)));
        rows.push_back(item_row(ACT_STEP, '0, 2));
        rows.push_back(item_row(ACT_START,
                                pack_line(32767, 32767, -32768, -32768, 24'hffffff)));
        rows.push_back(item_row(ACT_STEP, '0));
        rows.push_back(item_row(ACT_START, pack_line(5, 32767, 5, -32768, 24'h123456)));
        rows.push_back(item_row(ACT_STEP, '0));
        rows.push_back(item_row(ACT_START, pack_line(0, 32767, 3, 32767, 24'hff00ff)));
        rows.push_back(item_row(ACT_STEP, '0, 3));
        rows.push_back(item_row(ACT_START, pack_line(639, 479, 640, 480, 24'hab0000)));
        rows.push_back(item_row(ACT_STEP, '0));
        rows.push_back(item_row(ACT_START, pack_line(10, 2, 13, 9, 24'h00cd00)));
        rows.push_back(item_row(ACT_STEP, '0, 6));
        rows.push_back(item_row(ACT_START, pack_line(-1, -1, 4, 2, 24'h0000ef)));
        rows.push_back(item_row(ACT_STEP, '0, 3));
        rows.push_back(cfg_row(1, 1));
        rows.push_back(item_row(ACT_START, pack_line(0, 0, 1, 1, 24'hffffff)));
        rows.push_back(item_row(ACT_STEP, '0, 2));
        rows.push_back(cfg_row(4096, 4096));
        rows.push_back(item_row(ACT_START, pack_line(4095, 4094, 4093, 4096, 24'h808080)));
        rows.push_back(item_row(ACT_STEP, '0, 3));

        foreach (rows[i]) begin
            if (rows[i].cfg)
                reconfigure(rows[i].w, rows[i].h);
            else
                repeat (rows[i].reps)
                    send_item(rows[i].act, rows[i].d, rows[i].typed, rows[i].want);
        end

        // random part
        hold_req = 1'b1;
        while (items_sent < ITEMS) begin
            if ($urandom_range(0, 29) == 0) burst = !burst;
            if (items_sent % 300 < 20 && $urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 4))
                    0: begin w = 1; h = 4096; end
                    1: begin w = 4096; h = 1; end
                    2: begin w = 640; h = 480; end
                    default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
                endcase
                reconfigure(w, h);
            end
            if ($urandom_range(0, 6) == 0) begin
                // noise: fully random item
                send_item(logic'($urandom_range(0, 1)),
                          88'({$urandom(), $urandom(), $urandom()}));
            end else begin
                // well-formed line near the frame, stepped to its end, cut short or once past it
                mx = (frame_w > 100) ? 100 : int'(frame_w);
                my = (frame_h > 100) ? 100 : int'(frame_h);
                x1 = $urandom_range(0, mx + 8) - 4;
                y1 = $urandom_range(0, my + 8) - 4;
                span = $urandom_range(0, 16);
                dir = $urandom_range(0, 40) - 20;
                steep = $urandom_range(0, 1);
                if (steep)
                    send_item(ACT_START, pack_line(x1, y1, x1 + dir * span / 20,
                              y1 + (($urandom_range(0, 1)) ? span : -span),
                              24'($urandom())));
                else
                    send_item(ACT_START, pack_line(x1, y1,
                              x1 + (($urandom_range(0, 1)) ? span : -span),
                              y1 + dir * span / 20, 24'($urandom())));
                steps = (span == 0) ? 1 : span;
                if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, steps);
                else if ($urandom_range(0, 7) == 0) steps += 1;
                repeat (steps)
                    send_item(ACT_STEP, 88'({$urandom(), $urandom(), $urandom()}));
            end
        end

        // drain
        s_axis_tvalid = 1'b0;
        while (pair_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/alsp_pkg.sv
src/als_queue.sv
src/als_front.sv
src/als_back.sv
src/antialiased_line_stepper.sv
tb/testbench.sv
